// ----- rtl/core/mbsd_pkg.sv -----
`timescale 1ns / 1ps
package mbsd_pkg;

	localparam int WINDOW_BITS_DEF   = 32;
	localparam int MAX_WORD_BITS_DEF = 16;

	localparam int DATA_W  = 16;
	localparam int CFG_W   = 32;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BITS_PER_WORD = 2'd0,
		REG_MATCH_TARGET  = 2'd1,
		REG_MATCH_MASK    = 2'd2,
		REG_REPORT_MASK   = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [4:0]  bits_per_word;
		logic [31:0] match_target;
		logic [31:0] match_mask;
		logic [31:0] report_mask;
	} cfg_t;

	// Reset values leave the detector disarmed: a zero mask never equals a target of one.
	localparam logic [4:0]  RST_BITS_PER_WORD = 5'd16;
	localparam logic [31:0] RST_MATCH_TARGET  = 32'd1;
	localparam logic [31:0] RST_MATCH_MASK    = 32'd0;
	localparam logic [31:0] RST_REPORT_MASK   = 32'd0;

endpackage

// ----- rtl/core/mbsd_cfg.sv -----
`timescale 1ns / 1ps
module mbsd_cfg
	import mbsd_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output cfg_t                 cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bits_per_word <= RST_BITS_PER_WORD;
			cfg_q.match_target  <= RST_MATCH_TARGET;
			cfg_q.match_mask    <= RST_MATCH_MASK;
			cfg_q.report_mask   <= RST_REPORT_MASK;
		end else if (cfg_wen) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_BITS_PER_WORD: cfg_q.bits_per_word <= cfg_data[4:0];
				REG_MATCH_TARGET:  cfg_q.match_target  <= cfg_data;
				REG_MATCH_MASK:    cfg_q.match_mask    <= cfg_data;
				REG_REPORT_MASK:   cfg_q.report_mask   <= cfg_data;
				default:           cfg_q <= cfg_q;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ----- rtl/core/mbsd_scan.sv -----
`timescale 1ns / 1ps
module mbsd_scan
	import mbsd_pkg::*;
#(
	parameter int WINDOW_BITS   = WINDOW_BITS_DEF,
	parameter int MAX_WORD_BITS = MAX_WORD_BITS_DEF
) (
	input  cfg_t                    cfg,
	input  logic [WINDOW_BITS-1:0]  win,
	input  logic [DATA_W-1:0]       data_word,
	output logic                    found,
	output logic [WINDOW_BITS-1:0]  next_win,
	output logic [31:0]             match_value
);

	localparam int W  = WINDOW_BITS;
	localparam int M  = MAX_WORD_BITS;
	localparam int CW = (W > 32) ? W : 32;
	localparam int XW = (M > DATA_W) ? M : DATA_W;
	localparam int NW = $clog2(M + 1);

	logic [NW-1:0]  nb;
	logic [XW-1:0]  wx;
	logic [XW-1:0]  shifted;
	logic [M-1:0]   aligned;
	logic [W+M-1:0] ext;
	logic [W-1:0]   win_k [M+1];
	logic [W-1:0]   at_match;
	logic [CW-1:0]  at_cw;

	// Bits beyond the supported word length saturate.
	always_comb begin
		if ({1'b0, cfg.bits_per_word} > 6'(M)) begin
			nb = NW'(M);
		end else begin
			nb = NW'(cfg.bits_per_word);
		end
	end

	// The used bits are left-justified so that the first bit shifted in sits on top.
	assign wx      = XW'(data_word);
	assign shifted = wx << (NW'(M) - nb);
	assign aligned = shifted[M-1:0];
	assign ext     = {win, aligned};

	// After k bits the window is a fixed slice of the concatenation.
	always_comb begin
		for (int k = 0; k <= M; k++) begin
			win_k[k] = ext[M-k +: W];
		end
	end

	// The last matching position within the word wins.
	always_comb begin
		found    = 1'b0;
		at_match = '0;
		for (int k = 1; k <= M; k++) begin
			if (NW'(k) <= nb
			    && ((CW'(win_k[k]) & CW'(cfg.match_mask)) == CW'(cfg.match_target))
			    && (win_k[k] != {W{1'b1}})) begin
				found    = 1'b1;
				at_match = win_k[k];
			end
		end
	end

	assign next_win    = found ? at_match : win_k[nb];
	assign at_cw       = CW'(at_match);
	assign match_value = at_cw[31:0] & cfg.report_mask;

endmodule

// ----- rtl/core/masked_bit_sequence_detector_top.sv -----
`timescale 1ns / 1ps
// A word accepted into the input register is scanned there and its result registered when
// the result register is empty or being taken. Throughput: one word per cycle while res_ready
// holds; the input and result registers let a new word enter while a result waits to be taken.
// The scan of all bit positions of a word is one combinational pass from the window register.
// Reset (asynchronous, active low) empties both registers, clears the window and the held
// match, and loads the configuration defaults, which leave the detector disarmed.
module masked_bit_sequence_detector_top
	import mbsd_pkg::*;
#(
	parameter int WINDOW_BITS   = WINDOW_BITS_DEF,
	parameter int MAX_WORD_BITS = MAX_WORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wen,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	input  logic                 data_valid,
	output logic                 data_ready,
	input  logic [DATA_W-1:0]    data_word,
	output logic                 res_valid,
	input  logic                 res_ready,
	output logic                 found,
	output logic [31:0]          match_value
);

	cfg_t                   cfg;
	logic                   valid_s1;
	logic [DATA_W-1:0]      data_s1;
	logic [WINDOW_BITS-1:0] window_q;
	logic [31:0]            held_q;
	logic                   res_valid_q;
	logic                   found_q;
	logic [31:0]            value_q;
	logic                   advance;
	logic                   scan_found;
	logic [WINDOW_BITS-1:0] scan_win;
	logic [31:0]            scan_value;

	mbsd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	mbsd_scan #(
		.WINDOW_BITS   (WINDOW_BITS),
		.MAX_WORD_BITS (MAX_WORD_BITS)
	) u_scan (
		.cfg         (cfg),
		.win         (window_q),
		.data_word   (data_s1),
		.found       (scan_found),
		.next_win    (scan_win),
		.match_value (scan_value)
	);

	assign advance    = valid_s1 && (!res_valid_q || res_ready);
	assign data_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (data_ready) begin
			valid_s1 <= data_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (data_valid && data_ready) begin
			data_s1 <= data_word;
		end
	end

	// Any configuration write starts the search from an empty window.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= '0;
			held_q   <= '0;
		end else if (cfg_wen) begin
			window_q <= '0;
			held_q   <= '0;
		end else if (advance) begin
			window_q <= scan_win;
			if (scan_found) begin
				held_q <= scan_value;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= 1'b1;
		end else if (res_ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			found_q <= scan_found;
			value_q <= scan_found ? scan_value : held_q;
		end
	end

	assign res_valid   = res_valid_q;
	assign found       = found_q;
	assign match_value = value_q;

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 1ps
module tb;
	import mbsd_pkg::*;

	localparam int TOTAL_WORDS = 1490;
	localparam int CYCLE_LIMIT = 400000;
	localparam int LONG_HOLD   = 60;

	typedef struct {
		logic        found;
		logic [31:0] value;
	} match_result_t;

	typedef enum int {RX_OPEN, RX_BUSY, RX_SPARSE, RX_PERIODIC} rx_mode_t;

	// Tracks the detector's window and held match, and the results still owed by the block.
	class window_matcher;
		logic [4:0]    bpw;
		logic [31:0]   target;
		logic [31:0]   cmp_mask;
		logic [31:0]   rep_mask;
		logic [31:0]   window;
		logic [31:0]   held;
		match_result_t awaited_matches[$];
		int            errors;
		int            checked;

		function new();
			bpw      = RST_BITS_PER_WORD;
			target   = RST_MATCH_TARGET;
			cmp_mask = RST_MATCH_MASK;
			rep_mask = RST_REPORT_MASK;
			window   = '0;
			held     = '0;
			errors   = 0;
			checked  = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [31:0] v);
			case (idx)
				REG_BITS_PER_WORD: bpw = v[4:0];
				REG_MATCH_TARGET: target = v;
				REG_MATCH_MASK: cmp_mask = v;
				REG_REPORT_MASK: rep_mask = v;
			endcase
			window = '0;
			held   = '0;
		endfunction

		function int word_bits();
			return (bpw > MAX_WORD_BITS_DEF) ? MAX_WORD_BITS_DEF : int'(bpw);
		endfunction

		function void take_word(logic [15:0] w);
			logic [31:0]   win;
			logic [31:0]   at_hit;
			match_result_t r;
			win      = window;
			at_hit   = '0;
			r.found  = 1'b0;
			for (int b = word_bits() - 1; b >= 0; b--) begin
				win = {win[30:0], w[b]};
				// An all-ones window never counts as a hit, whatever the mask.
				if ((win & cmp_mask) == target && win != '1) begin
					held    = win & rep_mask;
					at_hit  = win;
					r.found = 1'b1;
				end
			end
			window  = r.found ? at_hit : win;
			r.value = held;
			awaited_matches.push_back(r);
		endfunction

		function void flag(string msg);
			errors++;
			if (errors <= 10)
				$display("mismatch: %s", msg);
		endfunction

		function void check_match(logic f, logic [31:0] v);
			match_result_t e;
			if (awaited_matches.size() == 0) begin
				flag($sformatf("result found=%0b value=%08h with no word outstanding", f, v));
				return;
			end
			e = awaited_matches.pop_front();
			if (f !== e.found)
				flag($sformatf("word %0d found: expected %0b, got %0b", checked, e.found, f));
			if (v !== e.value)
				flag($sformatf("word %0d match_value: expected %08h, got %08h",
					checked, e.value, v));
			checked++;
		endfunction

		function int pending();
			return awaited_matches.size();
		endfunction
	endclass

	logic              clk         = 1'b0;
	logic              arst_n      = 1'b0;
	logic              cfg_wen     = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0]  cfg_data    = '0;
	logic              data_valid  = 1'b0;
	logic              data_ready;
	logic [DATA_W-1:0] data_word   = '0;
	logic              res_valid;
	logic              res_ready   = 1'b0;
	logic              found;
	logic [31:0]       match_value;

	window_matcher     matcher;
	logic              hold_req    = 1'b0;
	int                words_sent  = 0;
	int                burst_left  = 0;
	int                cycles      = 0;
	int                hold_left   = 0;
	int                mode_left   = 0;
	int                rx_tick     = 0;
	rx_mode_t          rx_mode     = RX_OPEN;

	masked_bit_sequence_detector_top uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wen    (cfg_wen),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.data_valid (data_valid),
		.data_ready (data_ready),
		.data_word  (data_word),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.found      (found),
		.match_value(match_value)
	);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// The receiver switches between stall styles; a request from the stimulus forces a long hold-off.
	always @(posedge clk) begin
		rx_tick++;
		if (hold_req)
			hold_left = LONG_HOLD;
		if (mode_left == 0) begin
			rx_mode   = rx_mode_t'($urandom_range(0, 3));
			mode_left = $urandom_range(32, 256);
		end else begin
			mode_left--;
		end
		if (hold_left > 0) begin
			hold_left--;
			res_ready <= 1'b0;
		end else begin
			case (rx_mode)
				RX_OPEN: res_ready <= 1'b1;
				RX_BUSY: res_ready <= ($urandom_range(0, 9) < 7);
				RX_SPARSE: res_ready <= ($urandom_range(0, 9) < 3);
				default: res_ready <= (rx_tick % 4 != 3);
			endcase
		end
	end

	always @(posedge clk) begin
		if (res_valid && res_ready)
			matcher.check_match(found, match_value);
	end

	task automatic send_word(logic [15:0] w);
		int gap;
		data_valid <= 1'b1;
		data_word  <= w;
		do @(posedge clk); while (!data_ready);
		matcher.take_word(w);
		words_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			burst_left = $urandom_range(1, 24);
			gap        = $urandom_range(0, 6);
			if (gap > 0) begin
				data_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
	endtask

	function automatic logic [15:0] noise_word();
		case ($urandom_range(0, 9))
			0: return 16'h0000;
			1: return 16'hFFFF;
			default: return 16'($urandom);
		endcase
	endfunction

	// Feeds a 32-bit window image that agrees with the target on every compared bit, at a random bit
	// alignment; a broken sequence has one bit flipped.
	task automatic send_pattern(bit broken);
		int          n;
		int          lead;
		bit          stream[$];
		logic [31:0] pat;
		logic [15:0] w;
		n = matcher.word_bits();
		if (n == 0) begin
			send_word(noise_word());
			return;
		end
		pat = (matcher.target & matcher.cmp_mask) | ($urandom & ~matcher.cmp_mask);
		if (broken)
			pat[$urandom_range(0, 31)] ^= 1'b1;
		lead = $urandom_range(0, n - 1);
		repeat (lead) stream.push_back(1'($urandom));
		for (int i = 31; i >= 0; i--)
			stream.push_back(pat[i]);
		while (stream.size() % n != 0)
			stream.push_back(1'($urandom));
		while (stream.size() > 0) begin
			w = 16'($urandom);
			for (int j = n - 1; j >= 0; j--)
				w[j] = stream.pop_front();
			send_word(w);
		end
	endtask

	task automatic drain();
		data_valid <= 1'b0;
		do @(posedge clk); while (matcher.pending() != 0);
		repeat (3) @(posedge clk);
	endtask

	task automatic load_regs(logic [3:0] en, logic [31:0] bpw_v, logic [31:0] tgt,
		logic [31:0] msk, logic [31:0] rep);
		cfg_reg_t    order[4] = '{REG_BITS_PER_WORD, REG_MATCH_TARGET, REG_MATCH_MASK,
			REG_REPORT_MASK};
		logic [31:0] vals[4];
		vals = '{bpw_v, tgt, msk, rep};
		for (int i = 0; i < 4; i++) begin
			if (en[i]) begin
				cfg_wen   <= 1'b1;
				cfg_index <= order[i];
				cfg_data  <= vals[i];
				@(posedge clk);
				matcher.write_reg(order[i], vals[i]);
			end
		end
		cfg_wen <= 1'b0;
	endtask

	task automatic random_config();
		int          k;
		logic [31:0] bpw_v;
		logic [31:0] tgt;
		logic [31:0] msk;
		logic [31:0] rep;
		logic [3:0]  en;
		k = $urandom_range(1, 12);
		case ($urandom_range(0, 9))
			0, 1, 2, 3, 4: begin
				msk = ((32'd1 << k) - 32'd1) << $urandom_range(0, 32 - k);
				tgt = $urandom & msk;
			end
			5, 6: begin
				msk = '1;
				tgt = $urandom;
			end
			7: begin
				msk = $urandom & $urandom & $urandom;
				tgt = $urandom & msk;
			end
			8: begin
				msk = $urandom;
				tgt = $urandom;
			end
			default: begin
				msk = '0;
				tgt = '0;
			end
		endcase
		case ($urandom_range(0, 9))
			0: bpw_v = 32'd1;
			1: bpw_v = 32'd16;
			2: bpw_v = $urandom_range(0, 1) ? 32'd0 : 32'($urandom_range(17, 31));
			default: bpw_v = 32'($urandom_range(1, 16));
		endcase
		// Upper bits of the data bus are don't-care for the word size register.
		bpw_v[31:5] = 27'($urandom);
		case ($urandom_range(0, 3))
			0: rep = '1;
			1: rep = '0;
			default: rep = $urandom;
		endcase
		en = ($urandom_range(0, 4) == 0) ? 4'($urandom_range(1, 15)) : 4'hF;
		load_regs(en, bpw_v, tgt, msk, rep);
	endtask

	initial begin
		int phase;
		int first_word;
		int n_items;
		matcher = new();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Detector is disarmed out of reset.
		send_word(16'h0000);
		send_word(16'hFFFF);
		send_word(16'hA5A5);
		drain();
		// Zero bits per word: nothing shifts even with an always-true compare.
		load_regs(4'hF, 32'hFFFF_FFE0, 32'h0, 32'h0, 32'hFFFF_FFFF);
		send_word(16'h1234);
		send_word(16'hFFFF);
		drain();
		// Oversized word count saturates; an all-ones window is never a hit.
		load_regs(4'h1, 32'h0000_001F, 32'h0, 32'h0, 32'h0);
		send_word(16'hFFFF);
		send_word(16'hFFFF);
		send_word(16'h0001);
		drain();
		load_regs(4'hF, 32'd16, 32'h8000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(16'h8000);
		send_word(16'h0001);
		send_word(16'h0000);
		drain();
		load_regs(4'h6, 32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0);
		send_word(16'hFFFF);
		send_word(16'hFFFF);
		drain();
		load_regs(4'hF, 32'd1, 32'h1, 32'h1, 32'h0000_00FF);
		send_word(16'h0001);
		send_word(16'hFFFE);
		send_word(16'h0001);

		phase = 0;
		while (words_sent < TOTAL_WORDS) begin
			drain();
			random_config();
			if (phase % 6 == 2) begin
				hold_req <= 1'b1;
				@(posedge clk);
				hold_req <= 1'b0;
			end
			n_items    = $urandom_range(40, 160);
			first_word = words_sent;
			while (words_sent - first_word < n_items) begin
				if ($urandom_range(0, 9) < 7)
					send_pattern($urandom_range(0, 5) == 0);
				else
					send_word(noise_word());
				if (phase == 4 && words_sent - first_word >= n_items / 2
					&& words_sent - first_word < n_items / 2 + 2)
					drain();
			end
			phase++;
		end
		drain();
		repeat (8) @(posedge clk);
		if (matcher.errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/core/mbsd_pkg.sv
rtl/core/mbsd_cfg.sv
rtl/core/mbsd_scan.sv
rtl/core/masked_bit_sequence_detector_top.sv
sim/tb.sv
